@@ design/rmlu_pkg.sv @@
`default_nettype none

package rmlu_pkg;

  // Sizing of the lock unit.
  localparam int THREAD_BITS = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int COUNT_BITS  = 16;

  localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SIZE_BITS = $clog2(QUEUE_DEPTH + 1);

  // Field widths of the request and response.
  localparam int KIND_W   = 3;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 3;
  localparam int MOVED_W  = 5;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ENTER      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EXIT       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HOLDS      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WAIT       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOTIFY_ONE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOTIFY_ALL = 3'd5;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_QUEUED    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_OWNER = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd4;

  typedef logic [THREAD_BITS-1:0] thread_t;
  typedef logic [COUNT_BITS-1:0]  count_t;
  typedef logic [PTR_BITS-1:0]    ptr_t;
  typedef logic [SIZE_BITS-1:0]   size_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  thread_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                holds;
    logic                granted_valid;
    logic [TID_W-1:0]    granted_thread;
    logic [MOVED_W-1:0]  moved_count;
    logic                owner_valid;
    logic [TID_W-1:0]    owner_thread;
  } rsp_t;

  // One queue entry: a waiting thread and its saved recursion count.
  typedef struct packed {
    thread_t thr;
    count_t  cnt;
  } entry_t;

  // Queue control from the sequencer.
  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
  } fifo_ctl_t;

  // Queue status back to the sequencer.
  typedef struct packed {
    logic  empty;
    logic  full;
    logic  one;
    size_t size;
  } fifo_sts_t;

endpackage

`default_nettype wire

@@ design/recursive_monitor_lock_unit_top.sv @@
`default_nettype none

// Channel    Handshake                  Payload
// request    req_valid / req_stall      req : req_t (kind, thread_id)
// response   rsp_valid / rsp_stall      rsp : rsp_t (status ... owner_thread)
//
// A request is taken while the sequencer is idle and executed in its execute
// step. A notify-all stays in that step until its waiters are moved or it
// stops at a full entry queue, since the sequencer moves one condition waiter
// per cycle through the queue read port while the output register is free.
// Reset clears the lock holder and empties both queues at once; no clearing
// pass is needed. A stalled response holds the sequencer in its execute step,
// while a request may still be taken when the sequencer is idle.
module recursive_monitor_lock_unit_top import rmlu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  fifo_ctl_t eq_ctl;
  fifo_ctl_t cq_ctl;
  fifo_sts_t eq_sts;
  fifo_sts_t cq_sts;
  entry_t    eq_wd;
  entry_t    eq_rd;
  entry_t    cq_wd;
  entry_t    cq_rd;
  logic      out_free;
  logic      res_load;
  rsp_t      res;

  // The output register is free when empty or when its transaction completes.
  assign out_free = !rsp_valid || !rsp_stall;

  // Entry queue: threads waiting to acquire the lock.
  rmlu_fifo u_entry_q (
    .clk     (clk),
    .rst     (rst),
    .ctl     (eq_ctl),
    .wr_data (eq_wd),
    .rd_data (eq_rd),
    .sts     (eq_sts)
  );

  // Condition queue: threads that waited and wait for a notify.
  rmlu_fifo u_cond_q (
    .clk     (clk),
    .rst     (rst),
    .ctl     (cq_ctl),
    .wr_data (cq_wd),
    .rd_data (cq_rd),
    .sts     (cq_sts)
  );

  // Sequencer with the holder registers and the shared count unit.
  rmlu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .eq_ctl    (eq_ctl),
    .eq_wd     (eq_wd),
    .eq_rd     (eq_rd),
    .eq_sts    (eq_sts),
    .cq_ctl    (cq_ctl),
    .cq_wd     (cq_wd),
    .cq_rd     (cq_rd),
    .cq_sts    (cq_sts)
  );

  // Response register: one transaction waits here for the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

@@ design/rmlu_fifo.sv @@
`default_nettype none

// Circular FIFO of waiting threads. The head entry is read into a register;
// a read issued together with a pop fetches the entry behind the head.
module rmlu_fifo import rmlu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire fifo_ctl_t ctl,
  input  wire entry_t    wr_data,
  output entry_t         rd_data,
  output fifo_sts_t      sts
);

  localparam ptr_t  LAST_PTR = ptr_t'(QUEUE_DEPTH - 1);
  localparam size_t FULL_SIZE = size_t'(QUEUE_DEPTH);

  entry_t mem [QUEUE_DEPTH];
  ptr_t   head;
  ptr_t   tail;
  size_t  size;
  ptr_t   head_inc;
  ptr_t   tail_inc;
  ptr_t   rd_addr;

  assign head_inc = (head == LAST_PTR) ? '0 : head + ptr_t'(1);
  assign tail_inc = (tail == LAST_PTR) ? '0 : tail + ptr_t'(1);
  assign rd_addr  = ctl.pop ? head_inc : head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      size <= '0;
    end else begin
      if (ctl.push) begin
        tail <= tail_inc;
      end
      if (ctl.pop) begin
        head <= head_inc;
      end
      size <= size + size_t'(ctl.push) - size_t'(ctl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign sts.empty = (size == '0);
  assign sts.full  = (size == FULL_SIZE);
  assign sts.one   = (size == size_t'(1));
  assign sts.size  = size;

endmodule

`default_nettype wire

@@ design/rmlu_ctrl.sv @@
`default_nettype none

// Sequencer and lock holder state. One shared incrementer/decrementer serves
// the recursion count; a notify-all moves one waiter per cycle when not stalled.
module rmlu_ctrl import rmlu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_t      req,
  input  wire logic      out_free,
  output logic           res_load,
  output rsp_t           res,
  output fifo_ctl_t      eq_ctl,
  output entry_t         eq_wd,
  input  wire entry_t    eq_rd,
  input  wire fifo_sts_t eq_sts,
  output fifo_ctl_t      cq_ctl,
  output entry_t         cq_wd,
  input  wire entry_t    cq_rd,
  input  wire fifo_sts_t cq_sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [KIND_W-1:0] kind;
  thread_t           tid;
  logic              hv;
  logic              hv_next;
  thread_t           ht;
  thread_t           ht_next;
  count_t            cnt;
  count_t            cnt_next;
  size_t             moved;
  size_t             moved_next;
  logic              gv;
  logic              gv_next;
  thread_t           gt;
  thread_t           gt_next;
  logic [STATUS_W-1:0] stat;
  logic              owner;
  logic              release_lock;
  logic              cnt_dec;
  count_t            cnt_sum;
  logic              accept;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign owner     = hv && (ht == tid);

  // Shared count unit: add one or subtract one.
  assign cnt_sum = cnt + (cnt_dec ? COUNT_MAX : count_t'(1));

  always_comb begin
    state_next   = state;
    hv_next      = hv;
    ht_next      = ht;
    cnt_next     = cnt;
    moved_next   = moved;
    gv_next      = gv;
    gt_next      = gt;
    stat         = STAT_DONE;
    release_lock = 1'b0;
    cnt_dec      = 1'b0;
    res_load     = 1'b0;
    eq_ctl       = '0;
    cq_ctl       = '0;
    eq_wd        = '{thr: tid, cnt: '0};
    cq_wd        = '{thr: tid, cnt: cnt};

    if (state == ST_IDLE) begin
      if (accept) begin
        eq_ctl.rd_en = 1'b1;
        cq_ctl.rd_en = 1'b1;
        moved_next   = '0;
        gv_next      = 1'b0;
        gt_next      = '0;
        state_next   = ST_EXEC;
      end
    end else if (out_free) begin
      res_load = 1'b1;
      case (kind)
        KIND_ENTER: begin
          if (!hv) begin
            hv_next  = 1'b1;
            ht_next  = tid;
            cnt_next = '0;
          end else if (owner) begin
            if (cnt == COUNT_MAX) begin
              stat = STAT_OVERFLOW;
            end else begin
              cnt_next = cnt_sum;
            end
          end else if (eq_sts.full) begin
            stat = STAT_FULL;
          end else begin
            eq_ctl.push = 1'b1;
            stat        = STAT_QUEUED;
          end
        end
        KIND_EXIT: begin
          if (!owner) begin
            stat = STAT_NOT_OWNER;
          end else if (cnt != '0) begin
            cnt_dec  = 1'b1;
            cnt_next = cnt_sum;
          end else begin
            release_lock = 1'b1;
          end
        end
        KIND_WAIT: begin
          if (!owner) begin
            stat = STAT_NOT_OWNER;
          end else if (cq_sts.full) begin
            stat = STAT_FULL;
          end else begin
            cq_ctl.push  = 1'b1;
            release_lock = 1'b1;
            stat         = STAT_QUEUED;
          end
        end
        KIND_NOTIFY_ONE, KIND_NOTIFY_ALL: begin
          if (!cq_sts.empty) begin
            if (hv && eq_sts.full) begin
              stat = STAT_FULL;
            end else begin
              cq_ctl.pop   = 1'b1;
              cq_ctl.rd_en = 1'b1;
              moved_next   = moved + size_t'(1);
              if (!hv) begin
                hv_next  = 1'b1;
                ht_next  = cq_rd.thr;
                cnt_next = cq_rd.cnt;
                gv_next  = 1'b1;
                gt_next  = cq_rd.thr;
              end else begin
                eq_ctl.push = 1'b1;
                eq_wd       = cq_rd;
              end
              // Keep moving waiters unless this was the last one to move.
              if (kind == KIND_NOTIFY_ALL && !cq_sts.one) begin
                res_load = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase

      // Hand the lock to the oldest entry waiter, or free it.
      if (release_lock) begin
        if (!eq_sts.empty) begin
          eq_ctl.pop = 1'b1;
          hv_next    = 1'b1;
          ht_next    = eq_rd.thr;
          cnt_next   = eq_rd.cnt;
          gv_next    = 1'b1;
          gt_next    = eq_rd.thr;
        end else begin
          hv_next  = 1'b0;
          ht_next  = '0;
          cnt_next = '0;
        end
      end

      if (res_load) begin
        state_next = ST_IDLE;
      end
    end
  end

  always_comb begin
    res.status         = stat;
    res.holds          = hv_next && (ht_next == tid);
    res.granted_valid  = gv_next;
    res.granted_thread = gv_next ? TID_W'(gt_next) : '0;
    res.moved_count    = MOVED_W'(moved_next);
    res.owner_valid    = hv_next;
    res.owner_thread   = hv_next ? TID_W'(ht_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hv    <= 1'b0;
      ht    <= '0;
      cnt   <= '0;
      moved <= '0;
      gv    <= 1'b0;
      gt    <= '0;
    end else begin
      state <= state_next;
      hv    <= hv_next;
      ht    <= ht_next;
      cnt   <= cnt_next;
      moved <= moved_next;
      gv    <= gv_next;
      gt    <= gt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= req.kind;
      tid  <= thread_t'(req.thread_id);
    end
  end

`ifndef SYNTH
  a_free_count_zero: assert property (@(posedge clk) disable iff (rst)
    !hv |-> (cnt == '0))
    else $error("free lock with nonzero recursion count");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("response loaded while output register is occupied");

  a_eq_no_overrun: assert property (@(posedge clk) disable iff (rst)
    eq_ctl.push |-> !eq_sts.full)
    else $error("push into a full entry queue");

  a_cq_no_underrun: assert property (@(posedge clk) disable iff (rst)
    cq_ctl.pop |-> !cq_sts.empty)
    else $error("pop from an empty condition queue");

  a_load_ends_item: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after a response");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

// Lock unit testbench. A short table of directed transactions comes first. A
// randomized run follows, shaped by the state of the lock: it fills and
// drains the entry and condition queues. Every response is checked against
// the table or a predictor of holder, recursion count and both wait queues.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rmlu_pkg::*;

  // Kinds that the unit must ignore.
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  localparam int      RANDOM_ITEMS    = 900;
  localparam int      CHUNK_ITEMS     = 40;
  localparam int      HOLD_OFF_CHUNK  = 8;
  localparam int      HOLD_OFF_CYCLES = 300;
  localparam int      SETTLE_CYCLES   = 40;

  // Each chunk of the randomized run leans toward one kind of traffic.
  typedef enum int {GEN_MIX, GEN_FILL, GEN_DRAIN, GEN_NOISE} gen_mode_t;

  // One row of the directed table. When "typed" is set the response is
  // written into the row by hand; otherwise the predictor supplies it.
  typedef struct packed {
    req_t rq;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Predicted lock state: the holder, its recursion count, and the two
  // FIFOs of waiting threads with their saved counts.
  logic    held;
  thread_t holder;
  count_t  depth;
  entry_t  entry_waiters[$];
  entry_t  cond_waiters[$];

  // Responses owed by the unit, oldest first.
  rsp_t owed_responses[$];

  int fault_count = 0;

  // Idling controls. The stimulus process sets them per chunk; the response
  // side reads them on its own.
  bit source_idles = 1'b0;
  bit sink_idles   = 1'b0;
  bit hold_off     = 1'b0;

  recursive_monitor_lock_unit_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The run is bounded no matter what the unit does.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic req_t mk_req(logic [KIND_W-1:0] k, thread_t t);
    req_t r;
    r.kind = k;
    r.thread_id = t;
    return r;
  endfunction

  function automatic rsp_t ans(logic [STATUS_W-1:0] st, logic hl, logic gv, thread_t gt,
                               logic [MOVED_W-1:0] mv, logic ov, thread_t ot);
    rsp_t o;
    o.status = st;
    o.holds = hl;
    o.granted_valid = gv;
    o.granted_thread = gt;
    o.moved_count = mv;
    o.owner_valid = ov;
    o.owner_thread = ot;
    return o;
  endfunction

  function automatic plan_row_t row(logic [KIND_W-1:0] k, thread_t t, bit typed, rsp_t want);
    plan_row_t p;
    p.rq = mk_req(k, t);
    p.typed = typed;
    p.want = want;
    return p;
  endfunction

  function automatic string show(rsp_t x);
    return $sformatf("status=%0d holds=%0b granted=%0b/%02h moved=%0d owner=%0b/%02h",
                     x.status, x.holds, x.granted_valid, x.granted_thread,
                     x.moved_count, x.owner_valid, x.owner_thread);
  endfunction

  // Hands the lock to the oldest entry waiter, which resumes with its saved
  // count, or frees the lock when nobody is queued.
  function automatic rsp_t pass_lock(rsp_t o);
    entry_t e;
    if (entry_waiters.size() != 0) begin
      e = entry_waiters.pop_front();
      held = 1'b1;
      holder = e.thr;
      depth = e.cnt;
      o.granted_valid = 1'b1;
      o.granted_thread = e.thr;
    end else begin
      held = 1'b0;
      holder = '0;
      depth = '0;
    end
    return o;
  endfunction

  // Applies one request to the predicted state and returns the response the
  // unit must give for it.
  function automatic rsp_t apply_lock_request(req_t r);
    rsp_t    o;
    thread_t tid;
    entry_t  e;
    bit      moving;
    o = '0;
    tid = r.thread_id;
    case (r.kind)
      KIND_ENTER: begin
        if (!held) begin
          held = 1'b1;
          holder = tid;
          depth = '0;
        end else if (holder == tid) begin
          if (depth == COUNT_MAX) o.status = STAT_OVERFLOW;
          else depth = depth + 1'b1;
        end else if (entry_waiters.size() >= QUEUE_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          e.thr = tid;
          e.cnt = '0;
          entry_waiters.push_back(e);
          o.status = STAT_QUEUED;
        end
      end
      KIND_EXIT: begin
        if (!(held && holder == tid)) o.status = STAT_NOT_OWNER;
        else if (depth != '0) depth = depth - 1'b1;
        else o = pass_lock(o);
      end
      KIND_WAIT: begin
        if (!(held && holder == tid)) begin
          o.status = STAT_NOT_OWNER;
        end else if (cond_waiters.size() >= QUEUE_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          e.thr = tid;
          e.cnt = depth;
          cond_waiters.push_back(e);
          depth = '0;
          o = pass_lock(o);
          o.status = STAT_QUEUED;
        end
      end
      KIND_NOTIFY_ONE, KIND_NOTIFY_ALL: begin
        // With the lock free, the first waiter moved takes it directly.
        // Moving stops at a full entry queue.
        moving = 1'b1;
        while (moving && cond_waiters.size() != 0) begin
          if (held && entry_waiters.size() >= QUEUE_DEPTH) begin
            o.status = STAT_FULL;
            moving = 1'b0;
          end else begin
            e = cond_waiters.pop_front();
            if (!held) begin
              held = 1'b1;
              holder = e.thr;
              depth = e.cnt;
              o.granted_valid = 1'b1;
              o.granted_thread = e.thr;
            end else begin
              entry_waiters.push_back(e);
            end
            o.moved_count = o.moved_count + 1'b1;
            if (r.kind == KIND_NOTIFY_ONE) moving = 1'b0;
          end
        end
      end
      default: ;
    endcase
    o.holds = held && holder == tid;
    o.owner_valid = held;
    o.owner_thread = held ? holder : '0;
    return o;
  endfunction

  // Threads come mostly from a small pool so that requests collide, and
  // sometimes from the whole range.
  function automatic thread_t pick_thread();
    if ($urandom_range(0, 99) < 20) return thread_t'($urandom_range(0, 255));
    return thread_t'($urandom_range(0, 23));
  endfunction

  function automatic thread_t holder_or_any();
    if (held && $urandom_range(0, 99) < 85) return holder;
    return pick_thread();
  endfunction

  // Builds the next request from the current predicted state. Exits and
  // waits mostly come from the holder so that they get past the ownership
  // check; fill chunks pile threads onto both queues, drain chunks empty them.
  function automatic req_t make_request(gen_mode_t mode);
    req_t r;
    int   dice;
    dice = $urandom_range(0, 99);
    r.thread_id = pick_thread();
    case (mode)
      GEN_FILL: begin
        if (dice < 55) begin
          r.kind = KIND_ENTER;
        end else if (dice < 80) begin
          r.kind = KIND_WAIT;
          r.thread_id = holder_or_any();
        end else if (dice < 90) begin
          r.kind = KIND_NOTIFY_ALL;
        end else begin
          r.kind = KIND_NOTIFY_ONE;
        end
      end
      GEN_DRAIN: begin
        if (dice < 55) begin
          r.kind = KIND_EXIT;
          r.thread_id = holder_or_any();
        end else if (dice < 70) begin
          r.kind = KIND_NOTIFY_ONE;
        end else if (dice < 80) begin
          r.kind = KIND_NOTIFY_ALL;
        end else if (dice < 90) begin
          r.kind = KIND_ENTER;
        end else begin
          r.kind = KIND_HOLDS;
          r.thread_id = holder_or_any();
        end
      end
      GEN_MIX: begin
        if (dice < 25) begin
          r.kind = KIND_ENTER;
        end else if (dice < 35) begin
          r.kind = KIND_ENTER;
          r.thread_id = holder_or_any();
        end else if (dice < 55) begin
          r.kind = KIND_EXIT;
          r.thread_id = holder_or_any();
        end else if (dice < 70) begin
          r.kind = KIND_WAIT;
          r.thread_id = holder_or_any();
        end else if (dice < 78) begin
          r.kind = KIND_NOTIFY_ONE;
        end else if (dice < 84) begin
          r.kind = KIND_NOTIFY_ALL;
        end else begin
          r.kind = KIND_HOLDS;
          r.thread_id = holder_or_any();
        end
      end
      default: begin
        r.kind = KIND_W'($urandom_range(0, 7));
        r.thread_id = TID_W'($urandom_range(0, 255));
      end
    endcase
    return r;
  endfunction

  // Offers one request transaction and holds it until the unit takes it. At
  // the edge of acceptance the predictor is advanced and the owed response
  // queued. A typed response from the directed table takes the place of
  // the predicted one. Inputs change only by nonblocking assignment at the
  // rising edge, and the stall is sampled just after that edge, so it
  // carries the value the unit presented at the edge.
  task automatic issue(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    if (source_idles && $urandom_range(0, 99) < 20) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = apply_lock_request(r);
    owed_responses.push_back(typed ? typed_rsp : predicted);
  endtask

  // Response side stall pattern. Random bursts of stall while idling is on,
  // and one long hold-off on request, counted here, during which the
  // stimulus keeps offering transactions until the unit stalls its input.
  initial begin : response_pacing
    int span;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (sink_idles && $urandom_range(0, 99) < 8) begin
        span = $urandom_range(1, 17);
        rsp_stall <= 1'b1;
        repeat (span) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Every response transaction is matched against the oldest owed one, one
  // field at a time. Only the first ten faults are printed in full.
  always @(posedge clk) begin : response_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_responses.size() == 0) begin
        if (fault_count < 10) $display("unexpected response: %s", show(rsp));
        fault_count++;
      end else begin
        want = owed_responses.pop_front();
        if (rsp.status !== want.status || rsp.holds !== want.holds ||
            rsp.granted_valid !== want.granted_valid ||
            rsp.granted_thread !== want.granted_thread ||
            rsp.moved_count !== want.moved_count ||
            rsp.owner_valid !== want.owner_valid ||
            rsp.owner_thread !== want.owner_thread) begin
          if (fault_count < 10) begin
            $display("response mismatch at %0t", $realtime);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(rsp));
          end
          fault_count++;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    gen_mode_t mode;
    req_t      r;
    int        counted;
    int        chunk;
    int        n;
    int        dice;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    held = 1'b0;
    holder = '0;
    depth = '0;

    // The directed table. Rows with a typed response are those whose answer
    // is plain from the state at that point: errors, the free lock, grants.
    // The others rely on the predictor.
    plan.push_back(row(KIND_HOLDS, 8'h00, 1'b1, ans(STAT_DONE, 0, 0, 8'h00, 0, 0, 8'h00)));
    // Exit and wait on a free lock are not-owner errors.
    plan.push_back(row(KIND_EXIT, 8'hFF, 1'b1, ans(STAT_NOT_OWNER, 0, 0, 8'h00, 0, 0, 8'h00)));
    plan.push_back(row(KIND_WAIT, 8'h00, 1'b1, ans(STAT_NOT_OWNER, 0, 0, 8'h00, 0, 0, 8'h00)));
    // Notify with nobody on the condition queue moves nothing.
    plan.push_back(row(KIND_NOTIFY_ONE, 8'h07, 1'b1, ans(STAT_DONE, 0, 0, 8'h00, 0, 0, 8'h00)));
    plan.push_back(row(KIND_NOTIFY_ALL, 8'h07, 1'b1, ans(STAT_DONE, 0, 0, 8'h00, 0, 0, 8'h00)));
    // Unused kinds are ignored.
    plan.push_back(row(KIND_SPARE_6, 8'hFF, 1'b1, ans(STAT_DONE, 0, 0, 8'h00, 0, 0, 8'h00)));
    plan.push_back(row(KIND_SPARE_7, 8'h00, 1'b1, ans(STAT_DONE, 0, 0, 8'h00, 0, 0, 8'h00)));
    // Take the free lock, then once more recursively.
    plan.push_back(row(KIND_ENTER, 8'hFF, 1'b1, ans(STAT_DONE, 1, 0, 8'h00, 0, 1, 8'hFF)));
    plan.push_back(row(KIND_ENTER, 8'hFF, 1'b1, ans(STAT_DONE, 1, 0, 8'h00, 0, 1, 8'hFF)));
    plan.push_back(row(KIND_ENTER, 8'h00, 1'b1, ans(STAT_QUEUED, 0, 0, 8'h00, 0, 1, 8'hFF)));
    plan.push_back(row(KIND_EXIT, 8'h00, 1'b1, ans(STAT_NOT_OWNER, 0, 0, 8'h00, 0, 1, 8'hFF)));
    // The holder waits with one saved level; the entry waiter is granted.
    plan.push_back(row(KIND_WAIT, 8'hFF, 1'b1, ans(STAT_QUEUED, 0, 1, 8'h00, 0, 1, 8'h00)));
    plan.push_back(row(KIND_ENTER, 8'h5A, 1'b1, ans(STAT_QUEUED, 0, 0, 8'h00, 0, 1, 8'h00)));
    // Notify from a thread that does not hold the lock still works.
    plan.push_back(row(KIND_NOTIFY_ONE, 8'h5A, 1'b1, ans(STAT_DONE, 0, 0, 8'h00, 1, 1, 8'h00)));
    plan.push_back(row(KIND_WAIT, 8'h00, 1'b1, ans(STAT_QUEUED, 0, 1, 8'h5A, 0, 1, 8'h5A)));
    plan.push_back(row(KIND_NOTIFY_ALL, 8'h33, 1'b0, '0));
    // The waiter that was notified comes back with its saved level.
    plan.push_back(row(KIND_EXIT, 8'h5A, 1'b0, '0));
    plan.push_back(row(KIND_EXIT, 8'hFF, 1'b0, '0));
    plan.push_back(row(KIND_EXIT, 8'hFF, 1'b0, '0));
    plan.push_back(row(KIND_EXIT, 8'h00, 1'b1, ans(STAT_DONE, 0, 0, 8'h00, 0, 0, 8'h00)));
    // A notify while the lock is free grants it straight to the waiter.
    plan.push_back(row(KIND_ENTER, 8'hA5, 1'b0, '0));
    plan.push_back(row(KIND_WAIT, 8'hA5, 1'b1, ans(STAT_QUEUED, 0, 0, 8'h00, 0, 0, 8'h00)));
    plan.push_back(row(KIND_NOTIFY_ONE, 8'h12, 1'b1, ans(STAT_DONE, 0, 1, 8'hA5, 1, 1, 8'hA5)));
    plan.push_back(row(KIND_EXIT, 8'hA5, 1'b0, '0));

    // Synchronous reset, released at a rising edge.
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue(plan[i].rq, plan[i].typed, plan[i].want);

    // Randomized run in chunks. Each chunk picks a traffic mix and whether
    // either side idles; some chunks run with no idling at all. One chunk
    // drives transactions back to back into a long response hold-off so
    // that the unit fills up and has to stall its request side.
    counted = 0;
    chunk = 0;
    while (counted < RANDOM_ITEMS) begin
      dice = $urandom_range(0, 99);
      if (dice < 35) mode = GEN_MIX;
      else if (dice < 65) mode = GEN_FILL;
      else if (dice < 90) mode = GEN_DRAIN;
      else mode = GEN_NOISE;
      source_idles = ($urandom_range(0, 3) != 0);
      sink_idles = ($urandom_range(0, 3) != 0);
      if (chunk == HOLD_OFF_CHUNK) begin
        mode = GEN_MIX;
        source_idles = 1'b0;
        sink_idles = 1'b0;
        hold_off = 1'b1;
      end
      for (n = 0; n < CHUNK_ITEMS; n++) begin
        r = make_request(mode);
        issue(r, 1'b0, '0);
        if (r.kind <= KIND_NOTIFY_ALL) counted++;
      end
      chunk++;
    end

    // The last part runs without idling. Release everything: exits by
    // whoever holds the lock, notifies while it is free.
    source_idles = 1'b0;
    sink_idles = 1'b0;
    while (held || cond_waiters.size() != 0) begin
      if (held) issue(mk_req(KIND_EXIT, holder), 1'b0, '0);
      else issue(mk_req(KIND_NOTIFY_ALL, 8'h00), 1'b0, '0);
    end

    // Wait for every owed response, then a little longer to catch strays.
    req_valid <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && owed_responses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
